>>> sv/rbc_pkg.sv
// Shared types and constants for the radix base converter.
`default_nettype none

package rbc_pkg;

   localparam int DIGIT_SLOTS = 32;
   localparam int SLOT_AW     = $clog2(DIGIT_SLOTS);
   localparam int COUNT_W     = $clog2(DIGIT_SLOTS + 1);
   localparam int VALUE_W     = 31;
   localparam int BASE_W      = 6;
   localparam int DIGIT_W     = 6;

   localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

   typedef enum logic [1:0] {
      STATUS_DIGIT    = 2'd0,
      STATUS_EMPTY    = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   typedef struct packed {
      status_type         status;
      logic [VALUE_W-1:0] value;
      logic [BASE_W-1:0]  base;
   } job_type;

endpackage

`default_nettype wire

>>> sv/rbc_front.sv
// Front end: accepts numbers, evaluates their digits in the source base, classifies the value.
`default_nettype none

module rbc_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic [31:0]          req_digit_number,
   input  wire logic [3:0]           req_source_base,
   input  wire logic [5:0]           req_target_base,
   output logic                      push_valid,
   output rbc_pkg::job_type          push_job,
   input  wire logic                 push_ready
);
   import rbc_pkg::*;

   localparam int          PROD_W          = VALUE_W + 32;
   localparam logic [31:0] RECIP_TEN       = 32'hCCCC_CCCD;
   localparam int          RECIP_TEN_SHIFT = 35;
   localparam int          TERM_W          = VALUE_W + 5;
   localparam logic [BASE_W-1:0] BASE_MIN  = BASE_W'(2);
   localparam logic [BASE_W-1:0] BASE_MAX  = BASE_W'(36);

   typedef enum logic [2:0] {
      F_IDLE,
      F_MUL,
      F_DIG,
      F_ACC,
      F_PUSH
   } state_type;

   state_type           state_ff, state_in;
   logic [VALUE_W-1:0]  rest_ff, rest_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [3:0]          digit_ff, digit_in;
   logic [VALUE_W-1:0]  value_ff, value_in;
   logic                ovf_ff, ovf_in;
   logic [VALUE_W-1:0]  weight_ff, weight_in;
   logic                wbig_ff, wbig_in;
   logic [3:0]          sbase_ff, sbase_in;
   logic [BASE_W-1:0]   tbase_ff, tbase_in;
   job_type             job_ff, job_in;

   logic [VALUE_W-1:0]  quot;
   logic [TERM_W-1:0]   term;
   logic [TERM_W-1:0]   sum;
   logic [TERM_W-1:0]   wprod;
   logic [BASE_W-1:0]   tbase_sat;

   always_comb begin
      quot      = VALUE_W'(prod_ff >> RECIP_TEN_SHIFT);
      term      = TERM_W'(digit_ff) * TERM_W'(weight_ff);
      sum       = TERM_W'(value_ff) + term;
      wprod     = TERM_W'(weight_ff) * TERM_W'(sbase_ff);
      tbase_sat = req_target_base;
      if (req_target_base < BASE_MIN) begin
         tbase_sat = BASE_MIN;
      end else if (req_target_base > BASE_MAX) begin
         tbase_sat = BASE_MAX;
      end

      state_in  = state_ff;
      rest_in   = rest_ff;
      prod_in   = prod_ff;
      digit_in  = digit_ff;
      value_in  = value_ff;
      ovf_in    = ovf_ff;
      weight_in = weight_ff;
      wbig_in   = wbig_ff;
      sbase_in  = sbase_ff;
      tbase_in  = tbase_ff;
      job_in    = job_ff;

      case (state_ff)
         F_IDLE: begin
            if (start) begin
               tbase_in  = tbase_sat;
               sbase_in  = req_source_base;
               rest_in   = req_digit_number[VALUE_W-1:0];
               value_in  = '0;
               ovf_in    = 1'b0;
               weight_in = VALUE_W'(1);
               wbig_in   = 1'b0;
               if (req_digit_number == 32'd0 || req_digit_number[31]) begin
                  job_in.status = STATUS_EMPTY;
                  job_in.value  = '0;
                  job_in.base   = tbase_sat;
                  state_in      = F_PUSH;
               end else begin
                  state_in = F_MUL;
               end
            end
         end
         F_MUL: begin
            prod_in  = PROD_W'(rest_ff) * PROD_W'(RECIP_TEN);
            state_in = F_DIG;
         end
         F_DIG: begin
            digit_in = rest_ff[3:0] - {quot[0], 3'b000} - {quot[2:0], 1'b0};
            rest_in  = quot;
            state_in = F_ACC;
         end
         F_ACC: begin
            value_in  = sum[VALUE_W-1:0];
            ovf_in    = ovf_ff || (digit_ff != 4'd0 && wbig_ff) ||
                        (sum > TERM_W'(VALUE_MAX));
            weight_in = wprod[VALUE_W-1:0];
            wbig_in   = (sbase_ff != 4'd0) && (wbig_ff || wprod > TERM_W'(VALUE_MAX));
            if (rest_ff == '0) begin
               job_in.value = value_in;
               job_in.base  = tbase_ff;
               if (ovf_in) begin
                  job_in.status = STATUS_OVERFLOW;
               end else if (value_in == '0) begin
                  job_in.status = STATUS_EMPTY;
               end else begin
                  job_in.status = STATUS_DIGIT;
               end
               state_in = F_PUSH;
            end else begin
               state_in = F_MUL;
            end
         end
         F_PUSH: begin
            if (push_ready) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      rest_ff   <= rest_in;
      prod_ff   <= prod_in;
      digit_ff  <= digit_in;
      value_ff  <= value_in;
      ovf_ff    <= ovf_in;
      weight_ff <= weight_in;
      wbig_ff   <= wbig_in;
      sbase_ff  <= sbase_in;
      tbase_ff  <= tbase_in;
      job_ff    <= job_in;
   end

   assign busy       = (state_ff != F_IDLE);
   assign push_valid = (state_ff == F_PUSH);
   assign push_job   = job_ff;

endmodule

`default_nettype wire

>>> sv/rbc_queue.sv
// Short job queue between the front end and the back end.
`default_nettype none

module rbc_queue (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push_valid,
   input  wire rbc_pkg::job_type push_job,
   output logic             push_ready,
   input  wire logic        pop,
   output logic             pop_valid,
   output rbc_pkg::job_type pop_job
);
   import rbc_pkg::*;

   localparam int QUEUE_DEPTH = 2;
   localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   job_type           entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   always_comb begin
      push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
      pop_valid  = (count_ff != '0);
      pop_job    = entries_ff[rd_ptr_ff];
      do_push    = push_valid && push_ready;
      do_pop     = pop && pop_valid;

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

>>> sv/rbc_back.sv
// Back end: divides by the target base into the digit store and plays the digits out.
`default_nettype none

module rbc_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             pop_valid,
   input  wire rbc_pkg::job_type pop_job,
   output logic                  pop,
   output logic                  rsp_strobe,
   output logic [7:0]            rsp_digit_char,
   output logic                  rsp_last_digit,
   output logic [1:0]            rsp_status
);
   import rbc_pkg::*;

   localparam int        PROD_W    = 2 * VALUE_W;
   localparam int        RECIP_SH  = VALUE_W;
   localparam int        REM_W     = BASE_W + 1;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_A    = 8'h41;
   localparam logic [DIGIT_W-1:0] DIGIT_NINE = DIGIT_W'(9);
   localparam logic [7:0] TEN       = 8'd10;

   typedef enum logic [2:0] {
      B_IDLE,
      B_MUL,
      B_QD,
      B_FIX,
      B_READ
   } state_type;

   function automatic logic [VALUE_W-1:0] base_recip(input logic [BASE_W-1:0] b);
      logic [VALUE_W-1:0] r;
      case (b)
         6'd3:  r = 31'd715827882;
         6'd4:  r = 31'd536870912;
         6'd5:  r = 31'd429496729;
         6'd6:  r = 31'd357913941;
         6'd7:  r = 31'd306783378;
         6'd8:  r = 31'd268435456;
         6'd9:  r = 31'd238609294;
         6'd10: r = 31'd214748364;
         6'd11: r = 31'd195225786;
         6'd12: r = 31'd178956970;
         6'd13: r = 31'd165191049;
         6'd14: r = 31'd153391689;
         6'd15: r = 31'd143165576;
         6'd16: r = 31'd134217728;
         6'd17: r = 31'd126322567;
         6'd18: r = 31'd119304647;
         6'd19: r = 31'd113025455;
         6'd20: r = 31'd107374182;
         6'd21: r = 31'd102261126;
         6'd22: r = 31'd97612893;
         6'd23: r = 31'd93368854;
         6'd24: r = 31'd89478485;
         6'd25: r = 31'd85899345;
         6'd26: r = 31'd82595524;
         6'd27: r = 31'd79536431;
         6'd28: r = 31'd76695844;
         6'd29: r = 31'd74051160;
         6'd30: r = 31'd71582788;
         6'd31: r = 31'd69273666;
         6'd32: r = 31'd67108864;
         6'd33: r = 31'd65075262;
         6'd34: r = 31'd63161283;
         6'd35: r = 31'd61356675;
         6'd36: r = 31'd59652323;
         default: r = 31'd1073741824;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] to_ascii(input logic [DIGIT_W-1:0] d);
      logic [7:0] c;
      if (d > DIGIT_NINE) begin
         c = 8'(d) - TEN + CHAR_A;
      end else begin
         c = 8'(d) + CHAR_ZERO;
      end
      return c;
   endfunction

   state_type            state_ff, state_in;
   logic [VALUE_W-1:0]   value_ff, value_in;
   logic [BASE_W-1:0]    base_ff, base_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [VALUE_W-1:0]   quot_ff, quot_in;
   logic [VALUE_W-1:0]   qd_ff, qd_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [SLOT_AW-1:0]   idx_ff, idx_in;
   logic                 pend_ff, pend_in;
   logic                 pend_last_ff, pend_last_in;
   status_type           pend_status_ff, pend_status_in;
   logic                 rsp_strobe_ff;
   logic [7:0]           rsp_char_ff, rsp_char_in;
   logic                 rsp_last_ff;
   status_type           rsp_status_ff;

   logic [DIGIT_W-1:0]   store [DIGIT_SLOTS];
   logic [DIGIT_W-1:0]   rd_data_ff;
   logic                 wr_en;
   logic [SLOT_AW-1:0]   wr_addr;
   logic [DIGIT_W-1:0]   wr_data;

   logic [VALUE_W-1:0]   quot0;
   logic [REM_W-1:0]     rem0;
   logic [REM_W-1:0]     rem_fix;
   logic [VALUE_W-1:0]   quot_fix;

   always_comb begin
      quot0    = VALUE_W'(prod_ff >> RECIP_SH);
      rem0     = REM_W'(value_ff - qd_ff);
      rem_fix  = rem0;
      quot_fix = quot_ff;
      if (rem0 >= REM_W'(base_ff)) begin
         rem_fix  = rem0 - REM_W'(base_ff);
         quot_fix = quot_ff + VALUE_W'(1);
      end

      state_in       = state_ff;
      value_in       = value_ff;
      base_in        = base_ff;
      prod_in        = prod_ff;
      quot_in        = quot_ff;
      qd_in          = qd_ff;
      count_in       = count_ff;
      idx_in         = idx_ff;
      pend_in        = 1'b0;
      pend_last_in   = 1'b0;
      pend_status_in = STATUS_DIGIT;
      pop            = 1'b0;
      wr_en          = 1'b0;
      wr_addr        = count_ff[SLOT_AW-1:0];
      wr_data        = DIGIT_W'(rem_fix);

      case (state_ff)
         B_IDLE: begin
            pop = pop_valid;
            if (pop_valid) begin
               if (pop_job.status != STATUS_DIGIT) begin
                  pend_in        = 1'b1;
                  pend_last_in   = 1'b1;
                  pend_status_in = pop_job.status;
               end else begin
                  value_in = pop_job.value;
                  base_in  = pop_job.base;
                  count_in = '0;
                  state_in = B_MUL;
               end
            end
         end
         B_MUL: begin
            prod_in  = PROD_W'(value_ff) * PROD_W'(base_recip(base_ff));
            state_in = B_QD;
         end
         B_QD: begin
            quot_in  = quot0;
            qd_in    = VALUE_W'(quot0 * VALUE_W'(base_ff));
            state_in = B_FIX;
         end
         B_FIX: begin
            wr_en    = 1'b1;
            value_in = quot_fix;
            count_in = count_ff + COUNT_W'(1);
            if (quot_fix == '0) begin
               idx_in   = count_ff[SLOT_AW-1:0];
               state_in = B_READ;
            end else if (count_in == COUNT_W'(DIGIT_SLOTS)) begin
               pend_in        = 1'b1;
               pend_last_in   = 1'b1;
               pend_status_in = STATUS_OVERFLOW;
               count_in       = '0;
               state_in       = B_IDLE;
            end else begin
               state_in = B_MUL;
            end
         end
         B_READ: begin
            pend_in      = 1'b1;
            pend_last_in = (idx_ff == '0);
            if (idx_ff == '0) begin
               state_in = B_IDLE;
            end else begin
               idx_in = idx_ff - SLOT_AW'(1);
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase

      rsp_char_in = (pend_status_ff == STATUS_DIGIT) ? to_ascii(rd_data_ff) : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store[wr_addr] <= wr_data;
      end
      rd_data_ff <= store[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= B_IDLE;
         count_ff      <= '0;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= pend_ff;
      end
      value_ff       <= value_in;
      base_ff        <= base_in;
      prod_ff        <= prod_in;
      quot_ff        <= quot_in;
      qd_ff          <= qd_in;
      idx_ff         <= idx_in;
      pend_last_ff   <= pend_last_in;
      pend_status_ff <= pend_status_in;
      rsp_char_ff    <= rsp_char_in;
      rsp_last_ff    <= pend_last_ff;
      rsp_status_ff  <= pend_status_ff;
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_digit_char = rsp_char_ff;
   assign rsp_last_digit = rsp_last_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

`default_nettype wire

>>> sv/radix_base_converter.sv
// Top level of the radix base converter.
//
// Usage: drive req_digit_number, req_source_base and req_target_base and raise start;
// the transaction is taken at a rising edge where start is high and busy is low.
// The decimal digits of the number are weighed in the source base and the value is
// written out in the target base (saturated to 2..36) as ASCII, most significant first.
// Each result sits on the rsp_ ports for one cycle with rsp_strobe high; rsp_last_digit
// marks the final result of a transaction. Zero or negative numbers, and values that
// come to zero, give one result with status empty; values above 2^31-1 give one result
// with status overflow. The receiver cannot stall the result stream.
// Flow: for each decimal digit the front end does a multiply by the reciprocal of ten,
// a digit extract and a multiply-accumulate, and busy stays high through these steps and
// the push, longer while the queue is full. A two-entry queue decouples it from the back
// end, which for each output digit does a reciprocal multiply, quotient times base and a
// correction, then reads the store back one digit per cycle. The front end can take a new
// number while the back end still works on earlier ones.
// Reset empties the queue and idles both ends; no clearing pass.
`default_nettype none

module radix_base_converter (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [31:0] req_digit_number,
   input  wire logic [3:0]  req_source_base,
   input  wire logic [5:0]  req_target_base,
   output logic             rsp_strobe,
   output logic [7:0]       rsp_digit_char,
   output logic             rsp_last_digit,
   output logic [1:0]       rsp_status
);
   import rbc_pkg::*;

   logic    push_valid;
   logic    push_ready;
   job_type push_job;
   logic    pop;
   logic    pop_valid;
   job_type pop_job;

   rbc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_digit_number (req_digit_number),
      .req_source_base  (req_source_base),
      .req_target_base  (req_target_base),
      .push_valid       (push_valid),
      .push_job         (push_job),
      .push_ready       (push_ready)
   );

   rbc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_job    (pop_job)
   );

   rbc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .pop_valid      (pop_valid),
      .pop_job        (pop_job),
      .pop            (pop),
      .rsp_strobe     (rsp_strobe),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last_digit (rsp_last_digit),
      .rsp_status     (rsp_status)
   );

`ifndef NO_ASSERTIONS
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status != STATUS_DIGIT |-> rsp_last_digit && rsp_digit_char == 8'd0)
      else $error("status result without last mark or with a character");

   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("front end not busy after taking a transaction");

   assert property (@(posedge clock) disable iff (reset)
      push_valid && !push_ready |=> push_valid && $stable(push_job))
      else $error("front end dropped or changed a job while the queue was full");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status == STATUS_DIGIT |->
         (rsp_digit_char >= 8'h30 && rsp_digit_char <= 8'h39) ||
         (rsp_digit_char >= 8'h41 && rsp_digit_char <= 8'h5A))
      else $error("digit result outside 0-9 and A-Z");
`endif

endmodule

`default_nettype wire
